// ===== hw/rtl/bcus_pkg.sv =====
// package for the braille cell utf-8 store: sizes, op codes, word types
// and the command/status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package bcus_pkg;

    localparam int MAX_CELLS = 16;
    localparam int IDX_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int CFG_W     = 5;

    localparam logic [CFG_W-1:0] CELL_COUNT_RST = CFG_W'(16);

    // op codes of an input word
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_END    = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // utf-8 braille framing
    localparam logic [7:0] UTF_LEAD      = 8'hE2;
    localparam logic [7:0] UTF_MID_MASK  = 8'hFC;
    localparam logic [7:0] UTF_MID_BASE  = 8'hA0;
    localparam logic [7:0] UTF_CONT_MASK = 8'hC0;
    localparam logic [7:0] UTF_CONT_BASE = 8'h80;
    localparam logic [7:0] UTF_LOW_MASK  = 8'h3F;

    // position within a three-byte character
    localparam logic [1:0] PH_LEAD = 2'd0;
    localparam logic [1:0] PH_MID  = 2'd1;
    localparam logic [1:0] PH_LAST = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       empty_res;
    } t_out_item;

    typedef struct packed {
        logic parse;     // take a payload byte
        logic finish;    // close the payload
        logic rb_start;  // rewind the readback counters
        logic emit;      // drive one readback word
    } t_cmd;

    typedef struct packed {
        logic rb_empty;  // every cell in use is blank
        logic rb_final;  // current readback byte is the final one
    } t_stat;

endpackage

// ===== hw/rtl/bcus_ctrl.sv =====
// controller for the braille cell store: idle / readback state machine
// depends on bcus_pkg
`timescale 1ns / 1ps

module bcus_ctrl import bcus_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic [1:0] i_op,
    input  t_stat    i_stat,
    output t_cmd     o_cmd,
    output logic     o_busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.parse    = (i_op == OP_BYTE);
                    o_cmd.finish   = (i_op == OP_END);
                    o_cmd.rb_start = (i_op == OP_END) || (i_op == OP_GET);
                    if ((i_op == OP_END) || (i_op == OP_GET)) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.rb_empty || i_stat.rb_final) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state == ST_EMIT);

endmodule

// ===== hw/rtl/bcus_dp.sv =====
// datapath for the braille cell store: cell array, utf-8 parser,
// readback counters and the registered result word; depends on bcus_pkg
`timescale 1ns / 1ps

module bcus_dp import bcus_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic [7:0]       i_data_byte,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic             o_strobe,
    output t_out_item        o_result
);

    logic [CFG_W-1:0]     r_cell_count;
    logic [7:0]           r_cells [MAX_CELLS];
    logic [MAX_CELLS-1:0] r_nz;
    logic [CNT_W-1:0]     r_wi;
    logic [1:0]           r_phase;
    logic [7:0]           r_held;
    logic                 r_stopped;
    logic [IDX_W-1:0]     r_rb_idx;
    logic [1:0]           r_rb_ph;
    logic                 r_strobe;
    t_out_item            r_result;

    logic [CNT_W-1:0]     use_n;
    logic [MAX_CELLS-1:0] use_mask;
    logic [MAX_CELLS-1:0] live;
    logic [IDX_W-1:0]     hi;
    logic [7:0]           new_cell;
    logic                 cell_wr;
    logic [7:0]           rd_cell;
    t_out_item            n_result;

    // cells in use, saturated
    always_comb begin
        if (int'(r_cell_count) > MAX_CELLS) begin
            use_n = CNT_W'(MAX_CELLS);
        end else begin
            use_n = CNT_W'(r_cell_count);
        end
        for (int i = 0; i < MAX_CELLS; i++) begin
            use_mask[i] = (i < int'(use_n));
        end
    end

    // last non-blank cell in use
    assign live = r_nz & use_mask;
    always_comb begin
        hi = '0;
        for (int i = 0; i < MAX_CELLS; i++) begin
            if (live[i]) begin
                hi = IDX_W'(i);
            end
        end
    end

    assign o_stat.rb_empty = ~|live;
    assign o_stat.rb_final = (r_rb_ph == PH_LAST) && (r_rb_idx == hi);

    // parser
    assign new_cell = {r_held[1:0], i_data_byte[5:0]};
    assign cell_wr  = i_cmd.parse && !r_stopped && (r_wi < use_n) && (r_phase == PH_LAST)
                      && ((i_data_byte & UTF_CONT_MASK) == UTF_CONT_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= CELL_COUNT_RST;
        end else if (i_cfg_we) begin
            r_cell_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi      <= '0;
            r_phase   <= PH_LEAD;
            r_held    <= '0;
            r_stopped <= 1'b0;
        end else if (i_cmd.finish) begin
            r_wi      <= '0;
            r_phase   <= PH_LEAD;
            r_held    <= '0;
            r_stopped <= 1'b0;
        end else if (i_cmd.parse && !r_stopped) begin
            if (r_wi >= use_n) begin
                r_stopped <= 1'b1;
            end else begin
                case (r_phase)
                    PH_LEAD: begin
                        if (i_data_byte != UTF_LEAD) begin
                            r_stopped <= 1'b1;
                        end else begin
                            r_phase <= PH_MID;
                        end
                    end
                    PH_MID: begin
                        if ((i_data_byte & UTF_MID_MASK) != UTF_MID_BASE) begin
                            r_stopped <= 1'b1;
                        end else begin
                            r_held  <= i_data_byte;
                            r_phase <= PH_LAST;
                        end
                    end
                    default: begin
                        if (!cell_wr) begin
                            r_stopped <= 1'b1;
                        end else begin
                            r_wi    <= r_wi + CNT_W'(1);
                            r_phase <= PH_LEAD;
                            r_held  <= '0;
                            if ((r_wi + CNT_W'(1)) >= use_n) begin
                                r_stopped <= 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // cell storage, blank flags mark cells that read as zero
    always_ff @(posedge i_clk) begin
        if (cell_wr) begin
            r_cells[r_wi[IDX_W-1:0]] <= new_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz <= '0;
        end else if (cell_wr) begin
            r_nz[r_wi[IDX_W-1:0]] <= (new_cell != 8'h00);
        end else if (i_cmd.finish) begin
            for (int i = 0; i < MAX_CELLS; i++) begin
                if ((i >= int'(r_wi)) && use_mask[i]) begin
                    r_nz[i] <= 1'b0;
                end
            end
        end
    end

    // readback
    assign rd_cell = r_nz[r_rb_idx] ? r_cells[r_rb_idx] : 8'h00;

    always_comb begin
        n_result.last      = 1'b0;
        n_result.empty_res = 1'b0;
        case (r_rb_ph)
            PH_LEAD: n_result.out_byte = UTF_LEAD;
            PH_MID:  n_result.out_byte = UTF_MID_BASE | {6'd0, rd_cell[7:6]};
            default: begin
                n_result.out_byte = UTF_CONT_BASE | (rd_cell & UTF_LOW_MASK);
                n_result.last     = o_stat.rb_final;
            end
        endcase
        if (o_stat.rb_empty) begin
            n_result.out_byte  = 8'h00;
            n_result.last      = 1'b1;
            n_result.empty_res = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rb_idx <= '0;
            r_rb_ph  <= PH_LEAD;
        end else if (i_cmd.rb_start) begin
            r_rb_idx <= '0;
            r_rb_ph  <= PH_LEAD;
        end else if (i_cmd.emit) begin
            if (r_rb_ph == PH_LAST) begin
                r_rb_ph  <= PH_LEAD;
                r_rb_idx <= r_rb_idx + IDX_W'(1);
            end else begin
                r_rb_ph  <= r_rb_ph + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/braille_cell_utf8_store_core.sv =====
// top level of the braille cell utf-8 store: controller plus datapath
// depends on bcus_pkg, bcus_ctrl, bcus_dp
`timescale 1ns / 1ps

// a word is taken on a rising edge with start high and busy low. a payload
// byte (op 0) or an unused op is absorbed as it is taken and busy stays
// low. end of payload (op 1) and get (op 2) start a readback run: busy is
// high while one result word per cycle is formed: three per cell up to
// the last non-blank cell in use (at most 3 * 16 = 48), or one word for
// the empty result. words come out of a register in the cycle after they
// are formed, each for exactly one cycle with o_strobe high, and there is
// no way to hold them off; the final word of a run carries last and
// appears in the cycle busy drops, so the next command can be taken while
// it is shown. cell_count must be written by the user through i_cfg_we /
// i_cfg_data only while busy is low; the block does not enforce this.

module braille_cell_utf8_store_core import bcus_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_strobe,
    output t_out_item        o_result
);

    t_cmd  cmd;
    t_stat stat;

    // sequencing of parse, finish and readback
    bcus_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // cells, parser state and the result register
    bcus_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (i_item.data_byte),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule

// ===== hw/rtl/bcus_chk.sv =====
// port-level checker for the braille cell store, bound to the top level
// depends on bcus_pkg and braille_cell_utf8_store_core
`timescale 1ns / 1ps

module bcus_chk import bcus_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input logic      o_strobe,
    input t_out_item o_result
);

    // byte and unused ops finish in the accepting cycle
    a_short_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.op == OP_BYTE || i_item.op == OP_UNUSED)) |=> !busy)
        else $error("busy after a single-cycle op");

    // end and get always start a readback run
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.op == OP_END || i_item.op == OP_GET)) |=> busy)
        else $error("readback run did not start");

    // a run ends with its final word on the outputs
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_result.last))
        else $error("run ended without a final word");

    // words only come out of a run
    a_word_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("word outside a readback run");

    // the empty result is a run of one
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.empty_res) |-> (o_result.last && !busy))
        else $error("empty result not alone");

endmodule

bind braille_cell_utf8_store_core bcus_chk u_bcus_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
